// ===== sv/psrf_pkg.sv =====
package psrf_pkg;

	localparam int ADDR_W = 32;
	localparam int CTR_W  = 32;

	localparam logic             KIND_CHECK   = 1'b0;
	localparam logic             KIND_CLEAR   = 1'b1;
	localparam logic [CTR_W-1:0] WINDOW_RESET = 32'd64;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] source_addr;
		logic [CTR_W-1:0]  seq_counter;
	} psrf_req_t;

	typedef struct packed {
		logic accepted;
		logic new_source;
		logic table_full;
		logic counter_advanced;
	} psrf_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_DONE
	} psrf_state_t;

endpackage

// ===== sv/psrf_ram.sv =====
module psrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/per_source_replay_filter.sv =====
// Per-source anti-replay filter. Each request either checks a sender address and
// sequence counter against a table of up to SOURCES senders, or clears the table.
// The table lives in two single-port-read RAMs (addresses and highest counters),
// scanned one entry per cycle. A check reads the entries in order until one matches
// its address; a check whose address is not in the table is decided once the scan
// has run through all entries in use; a clear goes straight to its response.
// One request is in work at a time, and the next request is taken in the cycle after
// the response has moved into the output register. The response register lets a new
// request start while the previous response waits.
// replay_window is written through the cfg channel, which is always ready and is
// to be used only while no request is in work.
module per_source_replay_filter #(
	parameter int SOURCES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  psrf_pkg::psrf_req_t       in_req,
	output logic                      out_valid,
	input  logic                      out_ready,
	output psrf_pkg::psrf_rsp_t       out_rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [psrf_pkg::CTR_W-1:0] cfg_data
);

	import psrf_pkg::*;

	localparam int IDX_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int USED_W = $clog2(SOURCES + 1);
	localparam logic [USED_W-1:0] USED_MAX = USED_W'(SOURCES);

	psrf_state_t       state_q, state_d;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] idx_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  slot_s1;
	logic [IDX_W-1:0]  slot_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CTR_W-1:0]  cnt_q;
	logic [CTR_W-1:0]  last_q;
	logic [CTR_W-1:0]  window_q;
	psrf_rsp_t         res_q, res_d;
	psrf_rsp_t         out_rsp_q;
	logic              out_valid_q;

	logic [ADDR_W-1:0] tag_rdata;
	logic [CTR_W-1:0]  ctr_rdata;
	logic              tag_we, ctr_we;
	logic [IDX_W-1:0]  wr_idx;
	logic              issue, hit, reject, advance, out_free;
	logic [CTR_W-1:0]  lag;
	logic              res_load, used_inc, used_clr, scan_start, hit_take;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	assign issue    = (state_q == ST_SCAN) && (idx_q < used_q);
	assign hit      = pend_s1 && (tag_rdata == addr_q);
	assign lag      = last_q - cnt_q;
	assign reject   = (cnt_q <= last_q) && (lag > window_q);
	assign advance  = cnt_q > last_q;
	assign out_free = !out_valid_q || out_ready;

	psrf_ram #(.WIDTH(ADDR_W), .DEPTH(SOURCES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (wr_idx),
		.wdata (addr_q),
		.re    (issue),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (tag_rdata)
	);

	psrf_ram #(.WIDTH(CTR_W), .DEPTH(SOURCES)) u_ctr_ram (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (wr_idx),
		.wdata (cnt_q),
		.re    (issue),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ctr_rdata)
	);

	always_comb begin
		state_d    = state_q;
		tag_we     = 1'b0;
		ctr_we     = 1'b0;
		wr_idx     = slot_q;
		res_load   = 1'b0;
		res_d      = '0;
		used_inc   = 1'b0;
		used_clr   = 1'b0;
		scan_start = 1'b0;
		hit_take   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_req.kind == KIND_CLEAR) begin
						used_clr = 1'b1;
						res_load = 1'b1;
						state_d  = ST_DONE;
					end else begin
						scan_start = 1'b1;
						state_d    = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					hit_take = 1'b1;
					state_d  = ST_EVAL;
				end else if (!issue && !pend_s1) begin
					// scan exhausted: append, or pass on a full table
					res_load       = 1'b1;
					state_d        = ST_DONE;
					res_d.accepted = 1'b1;
					if (used_q < USED_MAX) begin
						tag_we                 = 1'b1;
						ctr_we                 = 1'b1;
						wr_idx                 = used_q[IDX_W-1:0];
						used_inc               = 1'b1;
						res_d.new_source       = 1'b1;
						res_d.counter_advanced = (cnt_q != '0);
					end else begin
						res_d.table_full = 1'b1;
					end
				end
			end
			ST_EVAL: begin
				res_load       = 1'b1;
				state_d        = ST_DONE;
				res_d.accepted = !reject;
				if (!reject && advance) begin
					ctr_we                 = 1'b1;
					res_d.counter_advanced = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			window_q    <= WINDOW_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (used_clr) begin
				used_q <= '0;
			end else if (used_inc) begin
				used_q <= used_q + 1'b1;
			end
			if (scan_start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q[IDX_W-1:0];
		if (scan_start) begin
			addr_q <= in_req.source_addr;
			cnt_q  <= in_req.seq_counter;
		end
		if (hit_take) begin
			slot_q <= slot_s1;
			last_q <= ctr_rdata;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == ST_DONE && out_free) begin
			out_rsp_q <= res_q;
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_MAX)
		else $error("fill count beyond table size");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_we |-> (state_q == ST_SCAN || state_q == ST_EVAL))
		else $error("table write outside scan or evaluate");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised without a finished request");

	a_new_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_rsp_q.new_source && !out_rsp_q.accepted))
		else $error("appended source rejected");

endmodule
